@@ rtl/rtca_pkg.sv @@
// rtca_pkg: shared constants, types and helpers for the tiered context arbiter
// no dependencies; imported by every module of the block
package rtca_pkg;

    localparam int NUM_CONTEXTS   = 64;
    localparam int NUM_SOURCES    = 16;
    localparam int NUM_TIERS      = 3;
    localparam int MAX_CANDIDATES = 64;
    localparam int REF_WIDTH      = 8;
    localparam int HOLD_WIDTH     = 5;
    localparam int STAMP_WIDTH    = 48;
    localparam int CTX_WIDTH      = 6;
    localparam int SRC_WIDTH      = 4;
    localparam int TIER_WIDTH     = 2;
    localparam int PRIO_WIDTH     = 16;
    localparam int POS_WIDTH      = 6;
    localparam int REF_DEPTH      = NUM_CONTEXTS * NUM_SOURCES * NUM_TIERS;
    localparam int REF_AW         = $clog2(REF_DEPTH);
    localparam int IN_WIDTH       = 32;
    localparam int OUT_WIDTH      = 72;

    localparam logic [REF_WIDTH-1:0]  REF_MAX  = '1;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
    localparam logic [REF_AW-1:0]     REF_LAST = REF_AW'(REF_DEPTH - 1);

    // operation codes
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_CAND    = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_EXEC    = 6'b000100,
        ST_REL_RD  = 6'b001000,
        ST_REL_CHK = 6'b010000,
        ST_OUT     = 6'b100000
    } state_t;

    // one context row: activation stamp and holder count per tier
    typedef struct packed {
        logic [STAMP_WIDTH-1:0]                stamp;
        logic [NUM_TIERS-1:0][HOLD_WIDTH-1:0]  hold;
    } ctx_row_t;

    typedef struct packed {
        logic                    changed;
        logic                    mismatch;
        logic                    ref_saturated;
        logic [7:0]              released_pairs;
        logic                    is_active;
        logic [TIER_WIDTH-1:0]   top_tier;
        logic [STAMP_WIDTH-1:0]  stamp_out;
        logic                    winner_found;
        logic [POS_WIDTH-1:0]    winner_index;
    } result_t;

    // candidate request to the run tracker
    typedef struct packed {
        logic                          go;
        logic                          last;
        logic                          active;
        logic [TIER_WIDTH-1:0]         tier;
        logic signed [PRIO_WIDTH-1:0]  prio;
        logic [STAMP_WIDTH-1:0]        stamp;
    } cand_req_t;

    typedef struct packed {
        logic                  found;
        logic [POS_WIDTH-1:0]  index;
    } cand_rsp_t;

    function automatic logic row_active(input ctx_row_t row);
        logic a;
        a = 1'b0;
        for (int t = 0; t < NUM_TIERS; t++) begin
            a = a | (row.hold[t] != '0);
        end
        return a;
    endfunction

    function automatic logic [TIER_WIDTH-1:0] row_top(input ctx_row_t row);
        logic [TIER_WIDTH-1:0] tt;
        tt = '0;
        for (int t = 0; t < NUM_TIERS; t++) begin
            if (row.hold[t] != '0) begin
                tt = TIER_WIDTH'(t);
            end
        end
        return tt;
    endfunction

    function automatic logic [REF_AW-1:0] ref_addr(input logic [CTX_WIDTH-1:0] c,
                                                   input logic [SRC_WIDTH-1:0] s,
                                                   input logic [TIER_WIDTH-1:0] t);
        return REF_AW'(c) * REF_AW'(NUM_SOURCES * NUM_TIERS)
             + REF_AW'(s) * REF_AW'(NUM_TIERS) + REF_AW'(t);
    endfunction

    function automatic logic [OUT_WIDTH-1:0] pack_result(input result_t r);
        return OUT_WIDTH'({r.winner_index, r.winner_found, r.stamp_out, r.top_tier,
                           r.is_active, r.released_pairs, r.ref_saturated,
                           r.mismatch, r.changed});
    endfunction

endpackage

@@ rtl/rtca_run.sv @@
// rtca_run: candidate run tracker, keeps the best active candidate of a run
// depends on rtca_pkg
module rtca_run (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtca_pkg::cand_req_t req,
    output rtca_pkg::cand_rsp_t rsp
);
    import rtca_pkg::*;

    logic [POS_WIDTH:0]            run_pos_reg;
    logic                          have_reg, have_next;
    logic [TIER_WIDTH-1:0]         tier_reg, tier_next;
    logic signed [PRIO_WIDTH-1:0]  prio_reg, prio_next;
    logic [STAMP_WIDTH-1:0]        stamp_reg, stamp_next;
    logic [POS_WIDTH-1:0]          pos_reg, pos_next;
    logic                          in_run, take;

    // compare against the current best
    always_comb begin
        in_run = run_pos_reg < (POS_WIDTH+1)'(MAX_CANDIDATES);
        take   = in_run && req.active &&
                 (!have_reg || req.tier > tier_reg ||
                  (req.tier == tier_reg && req.prio > prio_reg) ||
                  (req.tier == tier_reg && req.prio == prio_reg && req.stamp > stamp_reg));
        have_next  = have_reg | take;
        tier_next  = take ? req.tier  : tier_reg;
        prio_next  = take ? req.prio  : prio_reg;
        stamp_next = take ? req.stamp : stamp_reg;
        pos_next   = take ? run_pos_reg[POS_WIDTH-1:0] : pos_reg;
        rsp.found  = have_next;
        rsp.index  = have_next ? pos_next : '0;
    end

    // run state, cleared by the last candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_pos_reg <= '0;
            have_reg    <= 1'b0;
            tier_reg    <= '0;
            prio_reg    <= '0;
            stamp_reg   <= '0;
            pos_reg     <= '0;
        end else if (req.go) begin
            if (req.last) begin
                run_pos_reg <= '0;
                have_reg    <= 1'b0;
                tier_reg    <= '0;
                prio_reg    <= '0;
                stamp_reg   <= '0;
                pos_reg     <= '0;
            end else begin
                if (in_run) begin
                    run_pos_reg <= run_pos_reg + 1'b1;
                end
                have_reg  <= have_next;
                tier_reg  <= tier_next;
                prio_reg  <= prio_next;
                stamp_reg <= stamp_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

@@ rtl/refcounted_tiered_context_arbiter_core.sv @@
// push, pop, candidate and query pass through ST_EXEC and ST_OUT into the output register
// release walks all 192 context-tier pairs, each through ST_REL_RD and ST_REL_CHK, then ST_OUT
// one request at a time: a new one is taken only back in ST_IDLE, and any output stall holds ST_OUT
// after reset a clearing pass over all 3072 reference entries zeroes both memories; no request taken
// reset is synchronous, active low; the output register holds one result
// top level: memories, sequencer, output register; uses rtca_pkg and rtca_run
module refcounted_tiered_context_arbiter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[2:0], context_index[8:3], source_index[12:9], tier_level[14:13],
    // cand_priority[30:15], zero fill
    input  logic [rtca_pkg::IN_WIDTH-1:0] s_tdata,
    input  logic                          s_tlast,   // last_candidate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // changed[0], mismatch[1], ref_saturated[2], released_pairs[10:3],
    // is_active[11], top_tier[13:12], stamp_out[61:14], winner_found[62],
    // winner_index[68:63], zero fill
    output logic [rtca_pkg::OUT_WIDTH-1:0] m_tdata
);
    import rtca_pkg::*;

    state_t                       state_reg, state_next;
    logic [REF_WIDTH-1:0]         ref_mem [REF_DEPTH];
    ctx_row_t                     ctx_mem [NUM_CONTEXTS];
    logic [REF_WIDTH-1:0]         ref_rd_reg;
    ctx_row_t                     row_rd_reg;

    logic [2:0]                   op_reg;
    logic [CTX_WIDTH-1:0]         ctx_reg;
    logic [SRC_WIDTH-1:0]         src_reg;
    logic [TIER_WIDTH-1:0]        tier_reg;
    logic signed [PRIO_WIDTH-1:0] prio_reg;
    logic                         last_reg;

    logic [STAMP_WIDTH-1:0]       clock_reg, clock_next;
    logic [REF_AW-1:0]            clr_reg;
    logic [CTX_WIDTH-1:0]         rel_ctx_reg;
    logic [TIER_WIDTH-1:0]        rel_tier_reg;
    logic [7:0]                   rel_cnt_reg, rel_cnt_next;
    result_t                      res_reg, res_next;
    logic                         m_valid_reg;
    logic [OUT_WIDTH-1:0]         m_data_reg;

    logic                         accept;
    logic [REF_AW-1:0]            rd_addr;
    logic [CTX_WIDTH-1:0]         rd_ctx;
    logic                         ref_we, ctx_we;
    logic [REF_AW-1:0]            ref_wa;
    logic [REF_WIDTH-1:0]         ref_wd;
    logic [CTX_WIDTH-1:0]         ctx_wa;
    ctx_row_t                     ctx_wd;
    logic                         t_ok;
    logic [TIER_WIDTH-1:0]        tsel;
    logic [HOLD_WIDTH-1:0]        hcur;
    logic [TIER_WIDTH-1:0]        in_tier;
    logic                         rel_done;
    cand_req_t                    cand_req;
    cand_rsp_t                    cand_rsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign in_tier  = s_tdata[14:13];

    // read addresses: incoming request or release walk
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_ctx  = s_tdata[8:3];
            rd_addr = ref_addr(s_tdata[8:3], s_tdata[12:9],
                               (in_tier < TIER_WIDTH'(NUM_TIERS)) ? in_tier : '0);
        end else begin
            rd_ctx  = rel_ctx_reg;
            rd_addr = ref_addr(rel_ctx_reg, src_reg, rel_tier_reg);
        end
    end

    // memories, one read and one write port each
    always_ff @(posedge aclk) begin
        ref_rd_reg <= ref_mem[rd_addr];
        row_rd_reg <= ctx_mem[rd_ctx];
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (ctx_we) begin
            ctx_mem[ctx_wa] <= ctx_wd;
        end
    end

    // candidate request to the run tracker
    always_comb begin
        cand_req.go     = (state_reg == ST_EXEC) && (op_reg == OP_CAND);
        cand_req.last   = last_reg;
        cand_req.active = row_active(row_rd_reg);
        cand_req.tier   = row_top(row_rd_reg);
        cand_req.prio   = prio_reg;
        cand_req.stamp  = row_rd_reg.stamp;
    end

    rtca_run u_run (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cand_req),
        .rsp     (cand_rsp)
    );

    // read-modify-write and result formation
    always_comb begin
        state_next   = state_reg;
        clock_next   = clock_reg;
        rel_cnt_next = rel_cnt_reg;
        res_next     = res_reg;
        t_ok         = tier_reg < TIER_WIDTH'(NUM_TIERS);
        tsel         = t_ok ? tier_reg : '0;
        hcur         = row_rd_reg.hold[tsel];
        ref_we       = 1'b0;
        ref_wa       = ref_addr(ctx_reg, src_reg, tsel);
        ref_wd       = '0;
        ctx_we       = 1'b0;
        ctx_wa       = ctx_reg;
        ctx_wd       = row_rd_reg;
        rel_done     = (rel_ctx_reg == CTX_WIDTH'(NUM_CONTEXTS - 1)) &&
                       (rel_tier_reg == TIER_WIDTH'(NUM_TIERS - 1));
        unique case (state_reg)
            ST_CLEAR: begin
                ref_we = 1'b1;
                ref_wa = clr_reg;
                ref_wd = '0;
                ctx_we = clr_reg < REF_AW'(NUM_CONTEXTS);
                ctx_wa = clr_reg[CTX_WIDTH-1:0];
                ctx_wd = '0;
                if (clr_reg == REF_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_next     = '0;
                    rel_cnt_next = '0;
                    state_next   = (s_tdata[2:0] == OP_RELEASE) ? ST_REL_RD : ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_OUT;
                case (op_reg)
                    OP_PUSH: begin
                        if (t_ok) begin
                            if (ref_rd_reg == REF_MAX) begin
                                res_next.ref_saturated = 1'b1;
                            end else begin
                                ref_we = 1'b1;
                                ref_wd = ref_rd_reg + 1'b1;
                                if (ref_rd_reg == '0) begin
                                    res_next.changed = 1'b1;
                                    ctx_we = 1'b1;
                                    ctx_wd.hold[tsel] = (hcur == HOLD_MAX) ? hcur : hcur + 1'b1;
                                    if (!row_active(row_rd_reg)) begin
                                        clock_next   = clock_reg + 1'b1;
                                        ctx_wd.stamp = clock_reg + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    OP_POP: begin
                        if (t_ok) begin
                            if (ref_rd_reg == '0) begin
                                res_next.mismatch = 1'b1;
                            end else begin
                                ref_we = 1'b1;
                                ref_wd = ref_rd_reg - 1'b1;
                                if (ref_rd_reg == REF_WIDTH'(1)) begin
                                    res_next.changed = 1'b1;
                                    ctx_we = 1'b1;
                                    ctx_wd.hold[tsel] = (hcur == '0) ? hcur : hcur - 1'b1;
                                end
                            end
                        end
                    end
                    OP_CAND: begin
                        if (last_reg) begin
                            res_next.winner_found = cand_rsp.found;
                            res_next.winner_index = cand_rsp.index;
                        end
                    end
                    OP_QUERY: begin
                        if (row_active(row_rd_reg)) begin
                            res_next.is_active = 1'b1;
                            res_next.top_tier  = row_top(row_rd_reg);
                            res_next.stamp_out = row_rd_reg.stamp;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_REL_RD: begin
                state_next = ST_REL_CHK;
            end
            ST_REL_CHK: begin
                hcur   = row_rd_reg.hold[rel_tier_reg];
                ref_wa = ref_addr(rel_ctx_reg, src_reg, rel_tier_reg);
                ctx_wa = rel_ctx_reg;
                if (ref_rd_reg != '0) begin
                    ref_we = 1'b1;
                    ref_wd = '0;
                    ctx_we = 1'b1;
                    ctx_wd.hold[rel_tier_reg] = (hcur == '0) ? hcur : hcur - 1'b1;
                    if (rel_cnt_reg != 8'hFF) begin
                        rel_cnt_next = rel_cnt_reg + 1'b1;
                    end
                end
                if (rel_done) begin
                    res_next.released_pairs = rel_cnt_next;
                    res_next.changed        = rel_cnt_next != '0;
                    state_next              = ST_OUT;
                end else begin
                    state_next = ST_REL_RD;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clock_reg    <= '0;
            clr_reg      <= '0;
            rel_ctx_reg  <= '0;
            rel_tier_reg <= '0;
            rel_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            rel_cnt_reg <= rel_cnt_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept) begin
                rel_ctx_reg  <= '0;
                rel_tier_reg <= '0;
            end else if (state_reg == ST_REL_CHK) begin
                if (rel_tier_reg == TIER_WIDTH'(NUM_TIERS - 1)) begin
                    rel_tier_reg <= '0;
                    rel_ctx_reg  <= rel_ctx_reg + 1'b1;
                end else begin
                    rel_tier_reg <= rel_tier_reg + 1'b1;
                end
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            op_reg   <= s_tdata[2:0];
            ctx_reg  <= s_tdata[8:3];
            src_reg  <= s_tdata[12:9];
            tier_reg <= s_tdata[14:13];
            prio_reg <= s_tdata[30:15];
            last_reg <= s_tlast;
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= pack_result(res_reg);
        end
    end

endmodule

@@ rtl/rtca_checker.sv @@
// rtca_checker: port-level checks on the arbiter core, bound to the top level
// depends on rtca_pkg and refcounted_tiered_context_arbiter_core
module rtca_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtca_pkg::OUT_WIDTH-1:0] m_tdata
);
    import rtca_pkg::*;

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no result sets both changed and mismatch
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("changed and mismatch together");

    // no winner means index zero
    a_nowin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[62] |-> m_tdata[68:63] == '0)
        else $error("winner index without winner");

endmodule

bind refcounted_tiered_context_arbiter_core rtca_checker u_rtca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the tiered reference-counted context arbiter core
// drives requests from a directed table and a random stream, predicts each result
// and checks the result stream field by field; depends on rtca_pkg and the core rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtca_pkg::*;

    localparam int  RUN_LIMIT   = 400000;
    localparam int  TAIL_WAIT   = 450;
    localparam int  QUIET_ITEMS = 150;
    localparam int  RAND_ITEMS  = 1100;
    localparam logic [2:0] OP_NOP5 = 3'd5;
    localparam logic [2:0] OP_NOP6 = 3'd6;
    localparam logic [2:0] OP_NOP7 = 3'd7;

    typedef struct {
        logic                  changed;
        logic                  mismatch;
        logic                  ref_saturated;
        logic [7:0]            released_pairs;
        logic                  is_active;
        logic [1:0]            top_tier;
        logic [47:0]           stamp_out;
        logic                  winner_found;
        logic [5:0]            winner_index;
    } outcome_t;

    typedef struct {
        logic [2:0]            op;
        logic [5:0]            ctx;
        logic [3:0]            src;
        logic [1:0]            tier;
        logic signed [15:0]    prio;
        logic                  last;
        logic                  typed;
        outcome_t              want;
    } request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_WIDTH-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_WIDTH-1:0]  m_tdata;

    // arbiter mirror state
    logic [REF_WIDTH-1:0]   ref_tally [REF_DEPTH];
    logic [HOLD_WIDTH-1:0]  holder_tally [NUM_CONTEXTS*NUM_TIERS];
    logic [47:0]            ctx_stamp [NUM_CONTEXTS];
    logic [47:0]            stamp_ticks;
    int                     run_pos;
    logic                   run_has_best;
    logic [1:0]             run_best_tier;
    logic signed [15:0]     run_best_prio;
    logic [47:0]            run_best_stamp;
    int                     run_best_pos;

    request_t  requests [$];
    outcome_t  pending_results [$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    bit        squeeze = 1'b0;

    refcounted_tiered_context_arbiter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic outcome_t mk(logic ch, logic mm, logic sat, logic [7:0] rel,
                                    logic act, logic [1:0] top, logic [47:0] st,
                                    logic wf, logic [5:0] wi);
        outcome_t o;
        o.changed = ch;  o.mismatch = mm;  o.ref_saturated = sat;
        o.released_pairs = rel;  o.is_active = act;  o.top_tier = top;
        o.stamp_out = st;  o.winner_found = wf;  o.winner_index = wi;
        return o;
    endfunction

    function automatic logic ctx_live(int c);
        logic a;
        a = 1'b0;
        for (int t = 0; t < NUM_TIERS; t++) a |= (holder_tally[c*NUM_TIERS+t] != '0);
        return a;
    endfunction

    function automatic logic [1:0] ctx_top(int c);
        logic [1:0] tt;
        tt = '0;
        for (int t = 0; t < NUM_TIERS; t++)
            if (holder_tally[c*NUM_TIERS+t] != '0) tt = 2'(t);
        return tt;
    endfunction

    function automatic void clear_mirror();
        foreach (ref_tally[i]) ref_tally[i] = '0;
        foreach (holder_tally[i]) holder_tally[i] = '0;
        foreach (ctx_stamp[i]) ctx_stamp[i] = '0;
        stamp_ticks = '0;
        run_pos = 0;  run_has_best = 0;  run_best_tier = '0;
        run_best_prio = '0;  run_best_stamp = '0;  run_best_pos = 0;
    endfunction

    // advance the mirror by one request and return the outcome it causes
    function automatic outcome_t arbiter_step(request_t q);
        outcome_t r;
        int c, s, t, ri, hi, n;
        logic was, take;
        logic [1:0] ct;
        logic [47:0] cs;
        r = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        c = int'(q.ctx);  s = int'(q.src);  t = int'(q.tier);
        case (q.op)
            OP_PUSH, OP_POP: begin
                if (t < NUM_TIERS) begin
                    ri = (c*NUM_SOURCES + s)*NUM_TIERS + t;
                    hi = c*NUM_TIERS + t;
                    if (q.op == OP_PUSH) begin
                        if (ref_tally[ri] == REF_MAX) begin
                            r.ref_saturated = 1;
                        end else begin
                            ref_tally[ri]++;
                            if (ref_tally[ri] == 1) begin
                                was = ctx_live(c);
                                if (holder_tally[hi] != HOLD_MAX) holder_tally[hi]++;
                                if (!was) begin
                                    stamp_ticks++;
                                    ctx_stamp[c] = stamp_ticks;
                                end
                                r.changed = 1;
                            end
                        end
                    end else if (ref_tally[ri] == 0) begin
                        r.mismatch = 1;
                    end else begin
                        ref_tally[ri]--;
                        if (ref_tally[ri] == 0) begin
                            if (holder_tally[hi] != 0) holder_tally[hi]--;
                            r.changed = 1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                n = 0;
                for (int cc = 0; cc < NUM_CONTEXTS; cc++) begin
                    for (int tt = 0; tt < NUM_TIERS; tt++) begin
                        ri = (cc*NUM_SOURCES + s)*NUM_TIERS + tt;
                        if (ref_tally[ri] != 0) begin
                            ref_tally[ri] = '0;
                            if (holder_tally[cc*NUM_TIERS+tt] != 0)
                                holder_tally[cc*NUM_TIERS+tt]--;
                            if (n < 255) n++;
                        end
                    end
                end
                r.released_pairs = 8'(n);
                r.changed = (n != 0);
            end
            OP_CAND: begin
                if (run_pos < MAX_CANDIDATES) begin
                    if (ctx_live(c)) begin
                        ct = ctx_top(c);
                        cs = ctx_stamp[c];
                        take = !run_has_best || ct > run_best_tier
                            || (ct == run_best_tier && q.prio > run_best_prio)
                            || (ct == run_best_tier && q.prio == run_best_prio
                                && cs > run_best_stamp);
                        if (take) begin
                            run_has_best = 1;  run_best_tier = ct;
                            run_best_prio = q.prio;  run_best_stamp = cs;
                            run_best_pos = run_pos;
                        end
                    end
                    run_pos++;
                end
                if (q.last) begin
                    r.winner_found = run_has_best;
                    r.winner_index = run_has_best ? 6'(run_best_pos) : '0;
                    run_pos = 0;  run_has_best = 0;  run_best_tier = '0;
                    run_best_prio = '0;  run_best_stamp = '0;  run_best_pos = 0;
                end
            end
            OP_QUERY: begin
                if (ctx_live(c)) begin
                    r.is_active = 1;
                    r.top_tier = ctx_top(c);
                    r.stamp_out = ctx_stamp[c];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add(logic [2:0] op, int c, int s, int t, int p, logic last,
                       logic typed = 0, outcome_t want = '{default: '0});
        request_t q;
        q.op = op;  q.ctx = 6'(c);  q.src = 4'(s);  q.tier = 2'(t);
        q.prio = 16'(p);  q.last = last;  q.typed = typed;  q.want = want;
        requests = {requests, q};
    endtask

    // mostly a small pool of contexts so that requests interact
    function automatic int pick_ctx();
        return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    endfunction

    function automatic int pick_tier();
        return ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
    endfunction

    function automatic int pick_prio();
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) - 2
                                           : $urandom_range(0, 65535);
    endfunction

    task automatic build_directed();
        outcome_t z;
        z = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        // state right after reset, empty pop, first and repeated reference
        add(OP_QUERY, 0, 0, 0, 0, 0, 1, z);
        add(OP_POP, 0, 0, 0, 0, 0, 1, mk(0, 1, 0, 0, 0, 0, 0, 0, 0));
        add(OP_PUSH, 0, 0, 0, 0, 0, 1, mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
        add(OP_PUSH, 0, 0, 0, 0, 0, 1, z);
        add(OP_QUERY, 0, 0, 0, 0, 0, 1, mk(0, 0, 0, 0, 1, 0, 48'd1, 0, 0));
        // extremes of context, source and tier
        add(OP_PUSH, 63, 15, 2, -1, 1, 1, mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
        add(OP_PUSH, 63, 3, 1, 0, 0);
        add(OP_QUERY, 63, 0, 0, 0, 0, 1, mk(0, 0, 0, 0, 1, 2, 48'd2, 0, 0));
        // out-of-range tier and unused op codes
        add(OP_PUSH, 1, 2, 3, 0, 0, 1, z);
        add(OP_NOP5, 63, 15, 3, -1, 1, 1, z);
        add(OP_NOP6, 21, 10, 2, 12345, 0, 1, z);
        add(OP_NOP7, 42, 5, 1, -32768, 1, 1, z);
        // runs: nothing active, higher tier wins, full tie keeps earlier
        add(OP_CAND, 5, 0, 0, 100, 1, 1, z);
        add(OP_CAND, 0, 0, 0, -32768, 0, 1, z);
        add(OP_CAND, 63, 0, 0, 32767, 1, 1, mk(0, 0, 0, 0, 0, 0, 0, 1, 6'd1));
        add(OP_CAND, 0, 0, 0, 7, 0, 1, z);
        add(OP_CAND, 0, 0, 0, 7, 1, 1, mk(0, 0, 0, 0, 0, 0, 0, 1, 6'd0));
        // other request inside a run
        add(OP_CAND, 0, 0, 0, 0, 0);
        add(OP_QUERY, 0, 0, 0, 0, 0);
        add(OP_CAND, 63, 0, 0, -1, 1);
        // last reference dropped, release of a source
        add(OP_POP, 0, 0, 0, 0, 0);
        add(OP_POP, 0, 0, 0, 0, 0);
        add(OP_RELEASE, 0, 15, 0, 0, 0, 1, mk(1, 0, 0, 8'd1, 0, 0, 0, 0, 0));
        add(OP_RELEASE, 0, 15, 0, 0, 1, 1, z);
        add(OP_QUERY, 63, 0, 0, 0, 0);
    endtask

    task automatic build_random();
        int n, kind, len, c, s, t, overlong;
        n = 0;
        overlong = 0;
        // reference ceiling: one triple hammered past saturation
        c = $urandom_range(0, 63);  s = $urandom_range(0, 15);  t = $urandom_range(0, 2);
        for (int i = 0; i < 258; i++) add(OP_PUSH, c, s, t, pick_prio(), $urandom_range(0, 1));
        add(OP_QUERY, c, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++) add(OP_POP, c, s, t, 0, 0);
        n = 262;
        while (n < RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 38) begin
                add(($urandom_range(0, 9) < 6) ? OP_PUSH : OP_POP, pick_ctx(),
                    $urandom_range(0, 15), pick_tier(), pick_prio(), $urandom_range(0, 1));
                n++;
            end else if (kind < 58) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add(OP_CAND, pick_ctx(), $urandom_range(0, 15), $urandom_range(0, 3),
                        pick_prio(), i == len - 1);
                n += len;
            end else if (kind < 64) begin
                // stray candidate, may open or close a run among other requests
                add(OP_CAND, pick_ctx(), 0, 0, pick_prio(), $urandom_range(0, 3) == 0);
                n++;
            end else if (kind < 82) begin
                add(OP_QUERY, pick_ctx(), $urandom_range(0, 15), $urandom_range(0, 3),
                    pick_prio(), $urandom_range(0, 1));
                n++;
            end else if (kind < 86) begin
                add(OP_RELEASE, pick_ctx(), $urandom_range(0, 15), $urandom_range(0, 3),
                    pick_prio(), $urandom_range(0, 1));
                n++;
            end else if (kind < 90) begin
                add(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 15),
                    $urandom_range(0, 3), $urandom_range(0, 65535), $urandom_range(0, 1));
                n++;
            end else if (kind < 91 && overlong < 2) begin
                // run longer than the candidate limit
                len = $urandom_range(65, 72);
                for (int i = 0; i < len; i++)
                    add(OP_CAND, pick_ctx(), 0, 0, pick_prio(), i == len - 1);
                n += len;
                overlong++;
            end else begin
                add(OP_PUSH, pick_ctx(), $urandom_range(0, 3), $urandom_range(0, 2),
                    pick_prio(), 0);
                n++;
            end
        end
    endtask

    function automatic outcome_t unpack_result(logic [OUT_WIDTH-1:0] d);
        return mk(d[0], d[1], d[2], d[10:3], d[11], d[13:12], d[61:14], d[62], d[68:63]);
    endfunction

    // result checker
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.changed !== want.changed || got.mismatch !== want.mismatch
                    || got.ref_saturated !== want.ref_saturated
                    || got.released_pairs !== want.released_pairs
                    || got.is_active !== want.is_active || got.top_tier !== want.top_tier
                    || got.stamp_out !== want.stamp_out
                    || got.winner_found !== want.winner_found
                    || got.winner_index !== want.winner_index) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp ch=%0d mm=%0d sat=%0d rel=%0d act=%0d top=%0d st=%0d wf=%0d wi=%0d",
                                 want.changed, want.mismatch, want.ref_saturated,
                                 want.released_pairs, want.is_active, want.top_tier,
                                 want.stamp_out, want.winner_found, want.winner_index);
                        $display("         act ch=%0d mm=%0d sat=%0d rel=%0d act=%0d top=%0d st=%0d wf=%0d wi=%0d",
                                 got.changed, got.mismatch, got.ref_saturated,
                                 got.released_pairs, got.is_active, got.top_tier,
                                 got.stamp_out, got.winner_found, got.winner_index);
                    end
                end
            end
        end
    end

    // receiver stalls, plus one long hold-off to back the block up
    initial begin
        int burst;
        bit squeezed;
        squeezed = 0;
        forever begin
            @(posedge aclk);
            if (squeeze && !squeezed) begin
                squeezed = 1;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // request driver
    initial begin
        request_t q;
        outcome_t o;
        int total;
        clear_mirror();
        build_directed();
        build_random();
        total = requests.size();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < total; i++) begin
            q = requests[i];
            if (i == 400) squeeze = 1;
            if (i >= total - QUIET_ITEMS) quiet = 1;
            if (!quiet && !squeeze && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, q.prio, q.tier, q.src, q.ctx, q.op};
            s_tlast  <= q.last;
            do @(posedge aclk); while (!s_tready);
            o = arbiter_step(q);
            if (q.typed) o = q.want;
            pending_results = {pending_results, o};
            if (i >= 600) squeeze = 0;
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
